@@ rtl/dsil_pkg.sv @@
package dsil_pkg;

    localparam int KEY_W = 34;
    localparam int ID_W  = 16;
    localparam int CMD_W = 2;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EMIT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OBS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GROUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP    = 3'd4;

    localparam logic [CFG_W-1:0] GROUND_RESET = 32'd6076000;
    localparam logic [CFG_W-1:0] MAP_RESET    = 32'd3038000;

    // classified request handed from the front to the back
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_req;

endpackage

@@ rtl/dsil_front.sv @@
module dsil_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dsil_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dsil_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dsil_pkg::CMD_W-1:0]     i_cmd,
    input  logic [dsil_pkg::ID_W-1:0]      i_id,
    input  logic [dsil_pkg::POS_W-1:0]     i_x,
    input  logic [dsil_pkg::POS_W-1:0]     i_y,
    input  logic [dsil_pkg::POS_W-1:0]     i_z,
    input  logic                           i_map,
    output logic                           o_push,
    output dsil_pkg::t_req                 o_req,
    input  logic                           i_full
);
    import dsil_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT, S_PUSH} t_state;

    t_state            r_state;
    logic [CFG_W-1:0]  r_obs_x, r_obs_y, r_obs_z, r_ground, r_map_off;
    logic [CMD_W-1:0]  r_cmd;
    logic [ID_W-1:0]   r_id;
    logic              r_zg, r_map;
    logic [32:0]       r_d [3];
    logic [1:0]        r_cnt;
    logic [5:0]        r_it;
    logic [65:0]       r_prod;
    logic [67:0]       r_acc;
    logic [36:0]       r_rem;
    logic [KEY_W-1:0]  r_root;

    logic [32:0]       dx, dy, dz;
    logic [36:0]       rem_sh, trial;
    logic [KEY_W-1:0]  key;

    function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (~d + 33'd1) : d;
    endfunction

    assign dx = absdiff(i_x, r_obs_x);
    assign dy = absdiff(i_y, r_obs_y);
    assign dz = absdiff(i_z, r_obs_z);

    assign rem_sh = {r_rem[34:0], r_acc[67:66]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign key    = r_root + (r_zg ? {2'b00, r_ground} : '0) + (r_map ? {2'b00, r_map_off} : '0);

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;
    assign o_req   = '{cmd: r_cmd, id: r_id, key: key};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_x   <= '0;
            r_obs_y   <= '0;
            r_obs_z   <= '0;
            r_ground  <= GROUND_RESET;
            r_map_off <= MAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OBS_X:  r_obs_x   <= i_cfg_data;
                REG_OBS_Y:  r_obs_y   <= i_cfg_data;
                REG_OBS_Z:  r_obs_z   <= i_cfg_data;
                REG_GROUND: r_ground  <= i_cfg_data;
                REG_MAP:    r_map_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd  <= i_cmd;
                        r_id   <= i_id;
                        r_zg   <= (i_z == '0);
                        r_map  <= i_map;
                        r_d[0] <= dx;
                        r_d[1] <= dy;
                        r_d[2] <= dz;
                        r_cnt  <= '0;
                        r_acc  <= '0;
                        r_root <= '0;
                        if (i_cmd == CMD_INSERT) begin
                            r_state <= S_SQ;
                        end else if (i_cmd == CMD_EMIT || i_cmd == CMD_CLEAR) begin
                            r_state <= S_PUSH;
                        end
                    end
                end
                S_SQ: begin
                    if (r_cnt != 2'd3) begin
                        r_prod <= r_d[r_cnt] * r_d[r_cnt];
                    end
                    if (r_cnt != 2'd0) begin
                        r_acc <= r_acc + {2'b00, r_prod};
                    end
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_rem   <= '0;
                        r_it    <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    // one root bit per cycle, two radicand bits consumed
                    r_acc <= {r_acc[65:0], 2'b00};
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[KEY_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[KEY_W-2:0], 1'b0};
                    end
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'(KEY_W - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/dsil_queue.sv @@
module dsil_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsil_pkg::t_req i_req,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dsil_pkg::t_req o_req
);
    import dsil_pkg::*;

    t_req        r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ rtl/dsil_back.sv @@
module dsil_back #(
    parameter int CAPACITY = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  dsil_pkg::t_req             i_req,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_vres,
    output logic [dsil_pkg::ID_W-1:0]  o_id,
    output logic [dsil_pkg::KEY_W-1:0] o_key,
    output logic                       o_ovf,
    output logic                       o_last
);
    import dsil_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {B_IDLE, B_EMIT} t_state;

    t_state            r_state;
    logic [KEY_W-1:0]  r_key [CAPACITY];
    logic [ID_W-1:0]   r_cid [CAPACITY];
    logic [CNT_W-1:0]  r_count, r_left;
    logic              r_ovf, r_eovf, r_empty;
    logic [CAPACITY-1:0] keep;
    logic              out_free, full;

    assign out_free = !o_valid || i_ready;
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign o_pop    = (r_state == B_IDLE) && i_valid;

    // cells holding a key not below the new one stay; sorted order makes this a prefix
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            keep[i] = (i < int'(r_count)) && (r_key[i] >= i_req.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_req.cmd == CMD_INSERT && !full) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (!keep[i]) begin
                    if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
                        r_key[i] <= i_req.key;
                        r_cid[i] <= i_req.id;
                    end else begin
                        r_key[i] <= r_key[(i == 0) ? 0 : i - 1];
                        r_cid[i] <= r_cid[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end else if (r_state == B_EMIT && out_free && !r_empty) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                r_key[i] <= r_key[i + 1];
                r_cid[i] <= r_cid[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_state == B_EMIT) begin
            o_vres <= !r_empty;
            o_id   <= r_empty ? '0 : r_cid[0];
            o_key  <= r_empty ? '0 : r_key[0];
            o_ovf  <= r_eovf;
            o_last <= r_empty || (r_left == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // load a new result when streaming, else hold one that waits
            o_valid <= (r_state == B_EMIT && out_free) || (o_valid && !i_ready);
            case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        case (i_req.cmd)
                            CMD_INSERT: begin
                                if (full) r_ovf <= 1'b1;
                                else      r_count <= r_count + CNT_W'(1);
                            end
                            CMD_EMIT: begin
                                r_left  <= r_count;
                                r_eovf  <= r_ovf;
                                r_empty <= (r_count == '0);
                                r_state <= B_EMIT;
                            end
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_ovf   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                B_EMIT: begin
                    if (out_free) begin
                        r_left  <= r_left - CNT_W'(1);
                        if (r_empty || r_left == CNT_W'(1)) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/depth_sorted_insert_list_unit.sv @@
// Depth-sorted insert list. Requests arrive on the slave stream: insert computes
// key = isqrt(dx^2+dy^2+dz^2) (+ground_offset when pos_z is zero, +map_offset for
// the world map) and places the object into a list kept in descending key order,
// equal keys in arrival order; emit streams the list farthest first with tlast on
// the final entry (one empty result with valid_res 0 for an empty list), then
// empties it; clear empties it. Inserts into a full list are dropped and set the
// overflowed flag until the list is emptied. The front accepts an insert, squares
// it axis by axis on the shared 33x33 squaring multiplier and runs the bit-per-cycle
// square root; emit and clear go straight to the push. The back then moves one result
// per cycle while the output is not stalled. A two-entry request queue lets the
// front compute the next key while the back inserts or streams.
module depth_sorted_insert_list_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dsil_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dsil_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [111:0]                   s_tdata,  // object_id, pos_x, pos_y, pos_z
    input  logic [2:0]                     s_tuser,  // cmd, is_world_map
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [55:0]                    m_tdata,  // out_id, sort_key, zero fill
    output logic [1:0]                     m_tuser,  // valid_res, overflowed
    output logic                           m_tlast
);
    import dsil_pkg::*;

    t_req             f_req, q_req;
    logic             f_push, q_full, q_valid, b_pop;
    logic             vres, ovf;
    logic [ID_W-1:0]  oid;
    logic [KEY_W-1:0] okey;

    // front: hold config, classify request, compute key
    dsil_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(s_tvalid), .o_ready(s_tready),
        .i_cmd(s_tuser[1:0]), .i_id(s_tdata[15:0]),
        .i_x(s_tdata[47:16]), .i_y(s_tdata[79:48]), .i_z(s_tdata[111:80]),
        .i_map(s_tuser[2]),
        .o_push(f_push), .o_req(f_req), .i_full(q_full)
    );

    dsil_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_push), .i_req(f_req), .o_full(q_full),
        .i_pop(b_pop), .o_valid(q_valid), .o_req(q_req)
    );

    // back: sorted cells and the output register
    dsil_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_req(q_req), .o_pop(b_pop),
        .o_valid(m_tvalid), .i_ready(m_tready),
        .o_vres(vres), .o_id(oid), .o_key(okey), .o_ovf(ovf), .o_last(m_tlast)
    );

    assign m_tdata = {6'd0, okey, oid};
    assign m_tuser = {ovf, vres};

endmodule

@@ rtl/dsil_checker.sv @@
module dsil_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // only the final result of a run may be an empty one
    a_mid_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> m_tuser[0])
        else $error("empty result inside a run");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == '0)
        else $error("bad empty result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result after reset");
endmodule

bind depth_sorted_insert_list_unit dsil_checker u_dsil_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

@@ verif/depth_sorted_insert_list_unit_test.sv @@
`timescale 1ns / 100ps

module depth_sorted_insert_list_unit_test;
    import dsil_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 120;   // lets a last insert finish in the front
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one request as offered on the slave stream
    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
        logic             world_map;
    } t_request;

    // one emitted entry as expected on the master stream
    typedef struct {
        logic             valid_res;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
        logic             overflowed;
        logic             last;
    } t_entry;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [111:0]       s_tdata;   // object_id, pos_x, pos_y, pos_z
    logic [2:0]         s_tuser;   // cmd, is_world_map
    logic               m_tvalid;
    logic               m_tready;
    logic [55:0]        m_tdata;   // out_id, sort_key, zero fill
    logic [1:0]         m_tuser;   // valid_res, overflowed
    logic               m_tlast;

    depth_sorted_insert_list_unit #(.CAPACITY(LIST_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // predictor copy of the registers and the list
    logic [CFG_W-1:0] obs_x, obs_y, obs_z, ground_ofs, map_ofs;
    logic [KEY_W-1:0] list_key [LIST_DEPTH];
    logic [ID_W-1:0]  list_id  [LIST_DEPTH];
    int               list_len;
    logic             list_ovf;

    t_request request_q[$];
    t_entry   emit_expect_q[$];

    int  err_cnt;
    int  cycle_cnt;
    int  snd_idle_pct, rcv_idle_pct;
    int  n_insert, n_emit, n_clear, n_ignored, n_dropped, n_results, n_items;
    bit  req_taken;          // set when the last edge accepted a request
    bit  stall_arm;          // ask the receiver for one long hold-off
    bit  stall_done;
    int  hold_cnt;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // guard the run length
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("depth_sorted_insert_list_unit_test: done, errors");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
        err_cnt++;
    endtask

    // distance key: floor(sqrt(dx^2+dy^2+dz^2)) plus the offsets
    function automatic logic [KEY_W-1:0] depth_key_of(input t_request r);
        logic signed [32:0] d [3];
        logic [65:0]        mag, sum;
        logic [67:0]        trial;
        logic [KEY_W-1:0]   root;
        logic [KEY_W-1:0]   cand;
        d[0] = $signed({r.px[31], r.px}) - $signed({obs_x[31], obs_x});
        d[1] = $signed({r.py[31], r.py}) - $signed({obs_y[31], obs_y});
        d[2] = $signed({r.pz[31], r.pz}) - $signed({obs_z[31], obs_z});
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            mag = d[k][32] ? 66'(-d[k]) : 66'(d[k]);
            sum = sum + mag * mag;
        end
        root = '0;
        for (int b = KEY_W - 1; b >= 0; b--) begin
            cand = root | (34'd1 << b);
            trial = 68'(cand) * 68'(cand);
            if (trial <= 68'(sum))
                root = cand;
        end
        if (r.pz == '0)
            root = root + KEY_W'(ground_ofs);
        if (r.world_map)
            root = root + KEY_W'(map_ofs);
        return root;
    endfunction

    // apply one accepted request to the predicted list
    task automatic predict_request(input t_request r);
        logic [KEY_W-1:0] k;
        int               at;
        t_entry           e;
        case (r.cmd)
            CMD_INSERT: begin
                n_insert++;
                if (list_len >= LIST_DEPTH) begin
                    list_ovf = 1'b1;
                    n_dropped++;
                end else begin
                    k = depth_key_of(r);
                    at = 0;
                    while (at < list_len && list_key[at] >= k)
                        at++;
                    for (int j = list_len; j > at; j--) begin
                        list_key[j] = list_key[j-1];
                        list_id[j]  = list_id[j-1];
                    end
                    list_key[at] = k;
                    list_id[at]  = r.id;
                    list_len++;
                end
            end
            CMD_EMIT: begin
                n_emit++;
                if (list_len == 0) begin
                    e = '{1'b0, '0, '0, list_ovf, 1'b1};
                    emit_expect_q.push_back(e);
                end else begin
                    for (int j = 0; j < list_len; j++) begin
                        e = '{1'b1, list_id[j], list_key[j], list_ovf, j == list_len - 1};
                        emit_expect_q.push_back(e);
                    end
                end
                list_len = 0;
                list_ovf = 1'b0;
            end
            CMD_CLEAR: begin
                n_clear++;
                list_len = 0;
                list_ovf = 1'b0;
            end
            default: n_ignored++;
        endcase
    endtask

    // take requests at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            predict_request(request_q.pop_front());
            req_taken = 1'b1;
        end
    end

    // drive requests at the falling edge; hold the offer until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (request_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {request_q[0].pz, request_q[0].py, request_q[0].px,
                             request_q[0].id};
                s_tuser  <= {request_q[0].world_map, request_q[0].cmd};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // receiver: random back-pressure plus one long hold-off once results show up
    always @(negedge i_clk) begin
        if (stall_arm && !stall_done && m_tvalid) begin
            hold_cnt = 900;
            stall_done = 1'b1;
        end
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // check every result against the oldest expectation
    always @(posedge i_clk) begin
        t_entry e;
        if (i_rst_n && m_tvalid && m_tready) begin
            n_results++;
            if (emit_expect_q.size() == 0) begin
                report("unexpected result", {m_tlast, m_tuser, m_tdata}, 0);
            end else begin
                e = emit_expect_q.pop_front();
                if (m_tuser[0] !== e.valid_res) report("valid_res", m_tuser[0], e.valid_res);
                if (m_tdata[15:0] !== e.id) report("out_id", m_tdata[15:0], e.id);
                if (m_tdata[49:16] !== e.key) report("sort_key", m_tdata[49:16], e.key);
                if (m_tuser[1] !== e.overflowed) report("overflowed", m_tuser[1], e.overflowed);
                if (m_tlast !== e.last) report("last", m_tlast, e.last);
            end
        end
    end

    task automatic push_req(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic m);
        t_request r;
        r = '{c, id, x, y, z, m};
        request_q.push_back(r);
        n_items++;
    endtask

    // write one register between phases; mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_OBS_X:  obs_x = val;
            REG_OBS_Y:  obs_y = val;
            REG_OBS_Z:  obs_z = val;
            REG_GROUND: ground_ofs = val;
            REG_MAP:    map_ofs = val;
            default: ;
        endcase
    endtask

    // wait until all requests are taken and all results are back, then let the front settle
    task automatic wait_quiet();
        while (request_q.size() > 0 || s_tvalid || emit_expect_q.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // pick a coordinate: full range, near the observer (ties), the extremes, or modest
    function automatic logic [31:0] pick_pos(input logic [31:0] obs);
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2:    return obs + 32'($urandom_range(0, 6)) - 32'd3;
            3:    return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($urandom_range(0, 2000)) - 32'd1000;
        endcase
    endfunction

    // one frame: a run of inserts with random content, closed by an emit;
    // now and then a clear, an unused command, or an oversized run to overflow
    task automatic push_frame();
        int          n;
        logic [31:0] z;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
        for (int j = 0; j < n; j++) begin
            z = ($urandom_range(0, 3) == 0) ? 32'd0 : pick_pos(obs_z);
            push_req(CMD_INSERT, $urandom, pick_pos(obs_x), pick_pos(obs_y), z,
                     $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 40) == 0)
                push_req(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        if ($urandom_range(0, 7) == 0)
            push_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        push_req(CMD_EMIT, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic run_frames(input int budget);
        int stop_at;
        stop_at = n_items + budget;
        while (n_items < stop_at)
            push_frame();
        wait_quiet();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        obs_x = '0; obs_y = '0; obs_z = '0;
        ground_ofs = GROUND_RESET;
        map_ofs = MAP_RESET;
        list_len = 0;
        list_ovf = 1'b0;
        snd_idle_pct = 19;
        rcv_idle_pct = 67;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty emit, ties, ground and map offsets, field extremes,
        // unused command, clear with and without content
        push_req(CMD_EMIT, 16'h1234, 32'd0, 32'd0, 32'd0, 1'b0);
        push_req(CMD_INSERT, 16'h0000, 32'd3, 32'd4, 32'd0, 1'b0);
        push_req(CMD_INSERT, 16'hffff, 32'd3, 32'd4, 32'd0, 1'b0);
        push_req(CMD_INSERT, 16'h0001, 32'd0, 32'd5, 32'd0, 1'b1);
        push_req(CMD_INSERT, 16'h0002, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        push_req(CMD_INSERT, 16'h0003, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        push_req(CMD_INSERT, 16'h0004, 32'd0, 32'd0, 32'd1, 1'b0);
        push_req(CMD_INSERT, 16'h0005, 32'd0, 32'd0, 32'hffff_ffff, 1'b0);
        push_req(CMD_UNUSED, 16'h0006, 32'd9, 32'd9, 32'd9, 1'b1);
        push_req(CMD_INSERT, 16'h0007, 32'd0, 32'd0, 32'd0, 1'b0);
        push_req(CMD_EMIT, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0);
        push_req(CMD_INSERT, 16'h0008, 32'd100, 32'd0, 32'd7, 1'b0);
        push_req(CMD_CLEAR, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0);
        push_req(CMD_EMIT, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0);
        push_req(CMD_CLEAR, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0);
        push_req(CMD_INSERT, 16'h5a5a, 32'hffff_fffd, 32'd2, 32'd0, 1'b1);
        push_req(CMD_EMIT, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        wait_quiet();

        // phase one: random observer, sender idles lightly, receiver heavily
        write_reg(REG_OBS_X, $urandom);
        write_reg(REG_OBS_Y, 32'($urandom_range(0, 2000)) - 32'd1000);
        write_reg(REG_OBS_Z, $urandom);
        write_reg(REG_GROUND, $urandom);
        write_reg(REG_MAP, $urandom);
        run_frames(125);

        // phase two: register extremes, idling swapped
        snd_idle_pct = 67;
        rcv_idle_pct = 19;
        write_reg(REG_OBS_X, 32'h8000_0000);
        write_reg(REG_OBS_Y, 32'h7fff_ffff);
        write_reg(REG_OBS_Z, 32'h8000_0000);
        write_reg(REG_GROUND, 32'hffff_ffff);
        write_reg(REG_MAP, 32'hffff_ffff);
        run_frames(125);

        // phase three: zero offsets, no idling; the receiver holds off once long
        // enough that the request queue fills and the slave side stalls
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(REG_OBS_X, 32'd0);
        write_reg(REG_OBS_Y, $urandom);
        write_reg(REG_OBS_Z, 32'h7fff_ffff);
        write_reg(REG_GROUND, 32'd0);
        write_reg(REG_MAP, 32'd0);
        stall_arm = 1'b1;
        run_frames(125);

        $display("covered %0d requests: %0d inserts (%0d dropped on a full list), %0d emits,",
                 n_items, n_insert, n_dropped, n_emit);
        $display("  %0d clears, %0d unused commands, %0d results checked",
                 n_clear, n_ignored, n_results);
        if (err_cnt == 0)
            $display("depth_sorted_insert_list_unit_test: done, clean");
        else
            $display("depth_sorted_insert_list_unit_test: done, errors");
        $finish;
    end

endmodule
